// ----- src/mte_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mte_pkg: shared types and constants for multi-tap text entry
// Action and status codes, letter group tables, sequencer states and the
// control group that drives the edit state.
// ----------------------------------------------------------------------------
package mte_pkg;

   localparam int ACTION_W = 3;
   localparam int KEY_W    = 4;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 4;
   localparam int CHAR_W   = 7;
   localparam int CFG_W    = 5;
   localparam int CHOICE_W = 2;
   localparam int LEN_MAX  = 15;

   localparam logic [ACTION_W-1:0] ACT_KEY       = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_SWITCH    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_BACKSPACE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CONFIRM   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CANCEL    = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_EDIT   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_CHAR   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_CANCEL = 2'd2;

   localparam logic [CFG_W-1:0] MAX_LEN_RESET = 5'd16;

   localparam logic [CHAR_W-1:0] GROUP_CHARS [8][4] = '{
      '{7'h41, 7'h42, 7'h43, 7'h00},
      '{7'h44, 7'h45, 7'h46, 7'h00},
      '{7'h47, 7'h48, 7'h49, 7'h00},
      '{7'h4a, 7'h4b, 7'h4c, 7'h00},
      '{7'h4d, 7'h4e, 7'h4f, 7'h00},
      '{7'h50, 7'h51, 7'h52, 7'h53},
      '{7'h54, 7'h55, 7'h56, 7'h00},
      '{7'h57, 7'h58, 7'h59, 7'h5a}
   };

   localparam logic [2:0] GROUP_SIZE [8] = '{3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd4};

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_RESULT,
      SEQ_READ,
      SEQ_EMIT
   } seq_state_type;

   typedef struct packed {
      logic apply;
      logic clear;
   } edit_ctl_type;

endpackage
`default_nettype wire

// ----- src/mte_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mte_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mte_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- src/mte_edit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mte_edit: editing state of the text entry
// Holds cursor, pending key and letter choice; applies one action per
// command and issues the store write for a committed letter.
// ----------------------------------------------------------------------------
module mte_edit #(
   parameter int NAME_DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire mte_pkg::edit_ctl_type            ctl,
   input  wire logic [mte_pkg::ACTION_W-1:0]     action,
   input  wire logic [mte_pkg::KEY_W-1:0]        letter_key,
   input  wire logic [mte_pkg::CFG_W-1:0]        max_len,
   output logic      [mte_pkg::LEN_W-1:0]        cursor,
   output logic      [mte_pkg::CHAR_W-1:0]       candidate,
   output logic                                  wr_en,
   output logic      [$clog2(NAME_DEPTH)-1:0]    wr_addr,
   output logic      [mte_pkg::CHAR_W-1:0]       wr_data
);
   import mte_pkg::*;

   localparam int CAP_INT = (NAME_DEPTH - 1 < LEN_MAX) ? NAME_DEPTH - 1 : LEN_MAX;
   localparam logic [CFG_W-1:0] CAP = CFG_W'(CAP_INT);

   logic [LEN_W-1:0]    cursor_ff, cursor_in;
   logic [KEY_W-1:0]    pending_ff, pending_in;
   logic [CHOICE_W-1:0] choice_ff, choice_in;
   logic [CFG_W-1:0]    len_lim, room_lim;
   logic [2:0]          group_idx;
   logic [2:0]          choice_inc;
   logic [CHOICE_W-1:0] choice_adv;
   logic                has_pending, room, commit_ok, key_ok, do_commit;

   always_comb begin
      len_lim     = (max_len == '0) ? '0 : max_len - CFG_W'(1);
      room_lim    = (len_lim > CAP) ? CAP : len_lim;
      room        = {1'b0, cursor_ff} < room_lim;
      has_pending = pending_ff != '0;
      commit_ok   = has_pending && room;
      key_ok      = (letter_key >= KEY_W'(1)) && (letter_key <= KEY_W'(8));
      group_idx   = 3'(pending_ff - KEY_W'(1));
      candidate   = has_pending ? GROUP_CHARS[group_idx][choice_ff] : '0;
      choice_inc  = {1'b0, choice_ff} + 3'd1;
      choice_adv  = (choice_inc >= GROUP_SIZE[group_idx]) ? '0 : CHOICE_W'(choice_inc);
   end

   always_comb begin
      cursor_in  = cursor_ff;
      pending_in = pending_ff;
      choice_in  = choice_ff;
      do_commit  = 1'b0;
      if (ctl.clear) begin
         cursor_in  = '0;
         pending_in = '0;
         choice_in  = '0;
      end else if (ctl.apply) begin
         unique case (action)
            ACT_KEY: begin
               if (key_ok) begin
                  if (pending_ff == letter_key) begin
                     choice_in = choice_adv;
                  end else begin
                     do_commit  = commit_ok;
                     pending_in = letter_key;
                     choice_in  = '0;
                  end
               end
            end
            ACT_SWITCH: begin
               if (has_pending) begin
                  choice_in = choice_adv;
               end
            end
            ACT_BACKSPACE: begin
               if (cursor_ff != '0) begin
                  cursor_in  = cursor_ff - LEN_W'(1);
                  pending_in = '0;
                  choice_in  = '0;
               end
            end
            ACT_CONFIRM: begin
               do_commit = commit_ok;
            end
            default: begin
            end
         endcase
         if (do_commit) begin
            cursor_in = cursor_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff  <= '0;
         pending_ff <= '0;
         choice_ff  <= '0;
      end else begin
         cursor_ff  <= cursor_in;
         pending_ff <= pending_in;
         choice_ff  <= choice_in;
      end
   end

   assign cursor  = cursor_ff;
   assign wr_en   = do_commit;
   assign wr_addr = ($clog2(NAME_DEPTH))'(cursor_ff);
   assign wr_data = candidate;

endmodule
`default_nettype wire

// ----- src/multitap_text_entry.sv -----
`default_nettype none
// A non-confirm item passes the EXEC and RESULT states and gives its one
// result from RESULT. Confirm then alternates READ and EMIT, one character
// per EMIT, each set by the registered read of the name store.
// A new item is taken once the last result of the previous one is registered.
// Reset clears the edit state and sets max_len to 16; no clearing pass.
// ----------------------------------------------------------------------------
// multitap_text_entry: multi-tap keypad letter entry
// Sequencer over the edit state and the name store; streams the confirmed
// name one character per result through an output register.
// ----------------------------------------------------------------------------
module multitap_text_entry #(
   parameter int NAME_DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [mte_pkg::ACTION_W-1:0]     req_action,
   input  wire logic [mte_pkg::KEY_W-1:0]        req_letter_key,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [mte_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [mte_pkg::LEN_W-1:0]        rsp_text_length,
   output logic      [mte_pkg::CHAR_W-1:0]       rsp_pending_letter,
   output logic      [mte_pkg::CHAR_W-1:0]       rsp_name_char,
   output logic      [mte_pkg::LEN_W-1:0]        rsp_char_index,
   output logic                                  rsp_last,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mte_pkg::CFG_W-1:0]        csr_max_len
);
   import mte_pkg::*;

   localparam int AW = $clog2(NAME_DEPTH);

   seq_state_type        state_ff, state_in;
   logic [ACTION_W-1:0]  action_ff, action_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [LEN_W-1:0]     idx_ff, idx_in;
   logic [CFG_W-1:0]     max_len_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [LEN_W-1:0]     length_ff, length_in;
   logic [CHAR_W-1:0]    pend_ff, pend_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic [LEN_W-1:0]     cidx_ff, cidx_in;
   logic                 last_ff, last_in;
   logic                 load, slot_free, rd_en, is_last;
   edit_ctl_type         ctl;
   logic [LEN_W-1:0]     cursor;
   logic [CHAR_W-1:0]    candidate;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [CHAR_W-1:0]    wr_data;
   logic [CHAR_W-1:0]    rd_data;

   mte_edit #(.NAME_DEPTH(NAME_DEPTH)) u_edit (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .action     (action_ff),
      .letter_key (key_ff),
      .max_len    (max_len_ff),
      .cursor     (cursor),
      .candidate  (candidate),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   mte_ram #(.WIDTH(CHAR_W), .DEPTH(NAME_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (AW'(idx_ff)),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_last   = (idx_ff + LEN_W'(1)) == cursor;

   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      ctl       = '0;
      rd_en     = 1'b0;
      load      = 1'b0;
      status_in = status_ff;
      length_in = length_ff;
      pend_in   = pend_ff;
      char_in   = char_ff;
      cidx_in   = cidx_ff;
      last_in   = last_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            req_stall = 1'b0;
            csr_ready = 1'b1;
            if (req_valid) begin
               action_in = req_action;
               key_in    = req_letter_key;
               state_in  = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            if (action_ff == ACT_CANCEL) begin
               ctl.clear = 1'b1;
            end else begin
               ctl.apply = 1'b1;
            end
            state_in = SEQ_RESULT;
         end
         SEQ_RESULT: begin
            if (action_ff == ACT_CONFIRM && cursor != '0) begin
               idx_in   = '0;
               state_in = SEQ_READ;
            end else if (slot_free) begin
               load      = 1'b1;
               status_in = (action_ff == ACT_CANCEL) ? STAT_CANCEL : STAT_EDIT;
               length_in = cursor;
               pend_in   = candidate;
               char_in   = '0;
               cidx_in   = '0;
               last_in   = 1'b1;
               state_in  = SEQ_IDLE;
            end
         end
         SEQ_READ: begin
            rd_en    = 1'b1;
            state_in = SEQ_EMIT;
         end
         SEQ_EMIT: begin
            if (slot_free) begin
               load      = 1'b1;
               status_in = STAT_CHAR;
               length_in = cursor;
               pend_in   = '0;
               char_in   = rd_data;
               cidx_in   = idx_ff;
               last_in   = is_last;
               if (is_last) begin
                  ctl.clear = 1'b1;
                  state_in  = SEQ_IDLE;
               end else begin
                  idx_in   = idx_ff + LEN_W'(1);
                  state_in = SEQ_READ;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         max_len_ff   <= MAX_LEN_RESET;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_max_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      key_ff    <= key_in;
      if (load) begin
         status_ff <= status_in;
         length_ff <= length_in;
         pend_ff   <= pend_in;
         char_ff   <= char_in;
         cidx_ff   <= cidx_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_text_length    = length_ff;
   assign rsp_pending_letter = pend_ff;
   assign rsp_name_char      = char_ff;
   assign rsp_char_index     = cidx_ff;
   assign rsp_last           = last_ff;

endmodule
`default_nettype wire

// ----- src/mte_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mte_checker: port-level checks for multitap_text_entry
// Watches the result channel for stable stalled transfers and consistent
// field combinations per status.
// ----------------------------------------------------------------------------
module mte_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic [mte_pkg::ACTION_W-1:0]     req_action,
   input wire logic [mte_pkg::KEY_W-1:0]        req_letter_key,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [mte_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic [mte_pkg::LEN_W-1:0]        rsp_text_length,
   input wire logic [mte_pkg::CHAR_W-1:0]       rsp_pending_letter,
   input wire logic [mte_pkg::CHAR_W-1:0]       rsp_name_char,
   input wire logic [mte_pkg::LEN_W-1:0]        rsp_char_index,
   input wire logic                             rsp_last,
   input wire logic                             csr_valid,
   input wire logic                             csr_ready,
   input wire logic [mte_pkg::CFG_W-1:0]        csr_max_len
);
   import mte_pkg::*;

   logic unused_ok;
   assign unused_ok = req_valid ^ req_stall ^ (^req_action) ^ (^req_letter_key) ^
                      csr_valid ^ csr_ready ^ (^csr_max_len);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_name_char) && $stable(rsp_char_index) && $stable(rsp_last))
      else $error("stalled result changed");

   a_char_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_CHAR |->
      rsp_name_char != '0 && rsp_pending_letter == '0 &&
      rsp_char_index < rsp_text_length &&
      rsp_last == ((rsp_char_index + LEN_W'(1)) == rsp_text_length))
      else $error("name character result inconsistent");

   a_cancel_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_CANCEL |->
      rsp_last && rsp_text_length == '0 && rsp_pending_letter == '0 &&
      rsp_name_char == '0 && rsp_char_index == '0)
      else $error("cancel result inconsistent");

   a_edit_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_EDIT |->
      rsp_last && rsp_name_char == '0 && rsp_char_index == '0 && unused_ok == unused_ok)
      else $error("editing result inconsistent");

endmodule

bind multitap_text_entry mte_checker u_mte_checker (.*);
`default_nettype wire
